/* hw/rtl/pua_pkg.sv */
// Shared types, codes and helpers for the per-processor utilization admission block.
`timescale 1ns / 1ps

package pua_pkg;

   // Processor entries held by the block
   localparam int NUM_CPUS = 32;
   localparam int IDX_W    = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;
   localparam int CNT_W    = $clog2(NUM_CPUS + 1);

   // Field widths
   localparam int UTIL_W   = 17;
   localparam int FREE_W   = 19;
   localparam int TCOUNT_W = 16;
   localparam int HCPU_W   = 5;
   localparam int ACT_W    = 6;
   localparam int KIND_W   = 2;
   localparam int REQ_DW   = 48;
   localparam int RSP_DW   = 40;
   localparam int CSR_AW   = 3;
   localparam int CSR_DW   = 32;

   // Request kinds
   localparam logic [KIND_W-1:0] REQ_TEST    = 2'd0;
   localparam logic [KIND_W-1:0] REQ_CHANGE  = 2'd1;
   localparam logic [KIND_W-1:0] REQ_PLACE   = 2'd2;
   localparam logic [KIND_W-1:0] REQ_RELEASE = 2'd3;

   // Verdict codes
   localparam logic [KIND_W-1:0] V_REJECT  = 2'd0;
   localparam logic [KIND_W-1:0] V_ACCEPT  = 2'd1;
   localparam logic [KIND_W-1:0] V_PARTIAL = 2'd2;
   localparam logic [KIND_W-1:0] V_DONE    = 2'd3;

   // Register indexes (address bit 2)
   localparam logic REG_ACTIVE_CPUS  = 1'b0;
   localparam logic REG_CPU_CAPACITY = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_READ,
      ST_UPDATE,
      ST_DONE
   } state_type;

   // Controller to datapath
   typedef struct packed {
      logic load;
      logic scan_rd;
      logic acc_rd;
      logic acc_wr;
      logic rsp_load;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

   // Add a share to a free value, saturating at the free range
   function automatic logic [FREE_W-1:0] sat_add(input logic [FREE_W-1:0] a,
                                                 input logic [UTIL_W-1:0] b);
      logic [FREE_W:0] s;
      s = {1'b0, a} + (FREE_W + 1)'(b);
      return s[FREE_W] ? {FREE_W{1'b1}} : s[FREE_W-1:0];
   endfunction

endpackage

/* hw/rtl/pua_csr.sv */
// Configuration registers behind the APB-style port.
`timescale 1ns / 1ps

module pua_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pua_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pua_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pua_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready,
   output logic [pua_pkg::ACT_W-1:0]     active_cpus,
   output logic [pua_pkg::UTIL_W-1:0]    cpu_capacity,
   output logic                          cap_load
);
   import pua_pkg::*;

   logic [ACT_W-1:0]  active_ff;
   logic [UTIL_W-1:0] cap_ff;
   logic              wr;
   logic              sel;

   assign csr_pready = 1'b1;
   assign wr         = csr_psel && csr_penable && csr_pwrite;
   assign sel        = csr_paddr[2];
   assign cap_load   = wr && (sel == REG_CPU_CAPACITY);

   // Register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= ACT_W'(32);
         cap_ff    <= UTIL_W'(65536);
      end else if (wr) begin
         case (sel)
            REG_ACTIVE_CPUS:  active_ff <= csr_pwdata[ACT_W-1:0];
            REG_CPU_CAPACITY: cap_ff    <= csr_pwdata[UTIL_W-1:0];
            default:          active_ff <= active_ff;
         endcase
      end
   end

   // Read back
   always_comb begin
      case (sel)
         REG_ACTIVE_CPUS:  csr_prdata = CSR_DW'(active_ff);
         REG_CPU_CAPACITY: csr_prdata = CSR_DW'(cap_ff);
         default:          csr_prdata = '0;
      endcase
   end

   assign active_cpus  = active_ff;
   assign cpu_capacity = cap_ff;

endmodule

/* hw/rtl/pua_ctrl.sv */
// Request sequencer: accept, scan, read, update, deliver.
`timescale 1ns / 1ps

module pua_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  pua_pkg::status_type  status,
   output pua_pkg::cmd_type     cmd
);
   import pua_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:   if (req_tvalid) state_in = ST_SCAN;
         ST_SCAN:   if (status.scan_last) state_in = ST_DRAIN;
         ST_DRAIN:  state_in = ST_READ;
         ST_READ:   state_in = ST_UPDATE;
         ST_UPDATE: state_in = ST_DONE;
         ST_DONE:   if (status.out_free) state_in = ST_IDLE;
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs
   always_comb begin
      cmd        = '0;
      req_tready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            cmd.load   = req_tvalid;
         end
         ST_SCAN:   cmd.scan_rd  = 1'b1;
         ST_DRAIN:  cmd          = '0;
         ST_READ:   cmd.acc_rd   = 1'b1;
         ST_UPDATE: cmd.acc_wr   = 1'b1;
         ST_DONE:   cmd.rsp_load = status.out_free;
         default:   cmd          = '0;
      endcase
   end

endmodule

/* hw/rtl/pua_datapath.sv */
// Processor tables, scan logic, update arithmetic and the result register.
`timescale 1ns / 1ps

module pua_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  pua_pkg::cmd_type              cmd,
   output pua_pkg::status_type           status,
   input  logic [pua_pkg::REQ_DW-1:0]    req_tdata,
   input  logic [pua_pkg::KIND_W-1:0]    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [pua_pkg::RSP_DW-1:0]    rsp_tdata,
   output logic [pua_pkg::KIND_W-1:0]    rsp_tuser,
   input  logic [pua_pkg::ACT_W-1:0]     active_cpus,
   input  logic [pua_pkg::UTIL_W-1:0]    cpu_capacity,
   input  logic                          cap_load
);
   import pua_pkg::*;

   // Captured item
   logic [KIND_W-1:0] kind_ff;
   logic [UTIL_W-1:0] demand_ff;
   logic              has_period_ff;
   logic              skip_ff;
   logic              prefers_ff;
   logic              held_here_ff;
   logic [HCPU_W-1:0] hcpu_ff;
   logic [UTIL_W-1:0] hutil_ff;

   // Tables
   logic [FREE_W-1:0]   free_mem [NUM_CPUS];
   logic [TCOUNT_W-1:0] cnt_mem  [NUM_CPUS];
   logic [NUM_CPUS-1:0] fvalid_ff;
   logic [NUM_CPUS-1:0] cvalid_ff;
   logic [FREE_W-1:0]   free_rd_ff;
   logic [TCOUNT_W-1:0] cnt_rd_ff;
   logic                fv_rd_ff;
   logic                cv_rd_ff;

   // Scan state
   logic [IDX_W-1:0]  idx_ff;
   logic              scan_pend_ff;
   logic [IDX_W-1:0]  scan_idx_ff;
   logic              fit_ff, fit_in;
   logic [FREE_W-1:0] best_val_ff;
   logic [IDX_W-1:0]  best_idx_ff;

   // Result
   logic [TCOUNT_W-1:0] res_cnt_ff;
   logic                rsp_valid_ff;
   logic [RSP_DW-1:0]   rsp_data_ff;
   logic [KIND_W-1:0]   rsp_kind_ff;

   logic [6:0]          act_ext;
   logic [6:0]          served7;
   logic [CNT_W-1:0]    served;
   logic                hvalid;
   logic [IDX_W-1:0]    hcpu_idx;
   logic                give;
   logic                is_place;
   logic                is_rel;
   logic [IDX_W-1:0]    acc_addr;
   logic [IDX_W-1:0]    rd_addr;
   logic                rd_en;
   logic                wr_en;
   logic [FREE_W-1:0]   free_eff;
   logic [TCOUNT_W-1:0] cnt_eff;
   logic [FREE_W-1:0]   val_t;
   logic [FREE_W-1:0]   demand_ext;
   logic [FREE_W-1:0]   free_new;
   logic [TCOUNT_W-1:0] cnt_new;
   logic [KIND_W-1:0]   verdict;
   logic [HCPU_W-1:0]   chosen;
   logic [UTIL_W-1:0]   charged;

   // Served processor count, clamped to 1..NUM_CPUS
   assign act_ext = {1'b0, active_cpus};
   always_comb begin
      if (act_ext == 7'd0) begin
         served7 = 7'd1;
      end else if (act_ext > 7'(NUM_CPUS)) begin
         served7 = 7'(NUM_CPUS);
      end else begin
         served7 = act_ext;
      end
   end
   assign served = CNT_W'(served7);

   assign hvalid     = 32'(hcpu_ff) < NUM_CPUS;
   assign hcpu_idx   = IDX_W'(hcpu_ff);
   assign give       = hvalid && held_here_ff && (hutil_ff != '0);
   assign is_place   = (kind_ff == REQ_PLACE);
   assign is_rel     = (kind_ff == REQ_RELEASE);
   assign demand_ext = FREE_W'(demand_ff);

   assign status.scan_last = (CNT_W'(idx_ff) + CNT_W'(1)) == served;
   assign status.out_free  = !rsp_valid_ff || rsp_tready;

   // Item capture and scan index
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff       <= req_tuser;
         demand_ff     <= req_tdata[17] ? req_tdata[16:0] : '0;
         has_period_ff <= req_tdata[18];
         skip_ff       <= req_tdata[19];
         prefers_ff    <= req_tdata[20];
         held_here_ff  <= req_tdata[21];
         hcpu_ff       <= req_tdata[26:22];
         hutil_ff      <= req_tdata[43:27];
         idx_ff        <= '0;
      end else if (cmd.scan_rd) begin
         idx_ff <= idx_ff + IDX_W'(1);
      end
   end

   // Single read port: scan address or the target entry
   assign acc_addr = is_place ? best_idx_ff : hcpu_idx;
   assign rd_addr  = cmd.scan_rd ? idx_ff : acc_addr;
   assign rd_en    = cmd.scan_rd || cmd.acc_rd;
   assign wr_en    = cmd.acc_wr && (is_place || (is_rel && hvalid));

   always_ff @(posedge clock) begin
      if (rd_en) begin
         free_rd_ff <= free_mem[rd_addr];
         cnt_rd_ff  <= cnt_mem[rd_addr];
         fv_rd_ff   <= fvalid_ff[rd_addr];
         cv_rd_ff   <= cvalid_ff[rd_addr];
      end
      if (wr_en) begin
         free_mem[acc_addr] <= free_new;
         cnt_mem[acc_addr]  <= cnt_new;
      end
   end

   // Entry valid bits; an invalid entry reads as cpu_capacity and a zero count
   always_ff @(posedge clock) begin
      if (reset) begin
         fvalid_ff <= '0;
         cvalid_ff <= '0;
      end else begin
         if (cap_load) begin
            fvalid_ff <= '0;
         end else if (wr_en) begin
            fvalid_ff[acc_addr] <= 1'b1;
         end
         if (wr_en) begin
            cvalid_ff[acc_addr] <= 1'b1;
         end
      end
   end

   assign free_eff = fv_rd_ff ? free_rd_ff : FREE_W'(cpu_capacity);
   assign cnt_eff  = cv_rd_ff ? cnt_rd_ff : '0;

   // Fit test and argmax over the scanned entries
   assign val_t  = (kind_ff == REQ_CHANGE && give && scan_idx_ff == hcpu_idx) ?
                   sat_add(free_eff, hutil_ff) : free_eff;
   assign fit_in = fit_ff || (demand_ext <= val_t);

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_pend_ff <= 1'b0;
      end else begin
         scan_pend_ff <= cmd.scan_rd;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= idx_ff;
      if (cmd.load) begin
         fit_ff <= 1'b0;
      end else if (scan_pend_ff) begin
         fit_ff <= fit_in;
         if (scan_idx_ff == '0 || free_eff > best_val_ff) begin
            best_val_ff <= free_eff;
            best_idx_ff <= scan_idx_ff;
         end
      end
   end

   // Update arithmetic for place and release
   always_comb begin
      if (is_place) begin
         free_new = (free_eff >= demand_ext) ? free_eff - demand_ext : '0;
         cnt_new  = (cnt_eff == {TCOUNT_W{1'b1}}) ? cnt_eff : cnt_eff + TCOUNT_W'(1);
      end else if (is_rel) begin
         free_new = sat_add(free_eff, hutil_ff);
         cnt_new  = (cnt_eff != '0) ? cnt_eff - TCOUNT_W'(1) : '0;
      end else begin
         free_new = free_eff;
         cnt_new  = cnt_eff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.acc_wr) begin
         res_cnt_ff <= (is_place || hvalid) ? cnt_new : '0;
      end
   end

   // Verdict and result fields
   always_comb begin
      if (is_place || is_rel) begin
         verdict = V_DONE;
      end else if (!has_period_ff || !(skip_ff || fit_ff)) begin
         verdict = V_REJECT;
      end else if (prefers_ff) begin
         verdict = V_PARTIAL;
      end else begin
         verdict = V_ACCEPT;
      end
   end
   assign chosen  = is_place ? HCPU_W'(best_idx_ff) : hcpu_ff;
   assign charged = is_place ? demand_ff : '0;

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_kind_ff <= verdict;
         rsp_data_ff <= {2'b00, res_cnt_ff, charged, chosen};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;

endmodule

/* hw/rtl/percpu_utilization_admission.sv */
// Top level of the per-processor utilization admission block.
//
//   Channel   Dir   Handshake           Content
//   req_*     in    tvalid/tready       request kind in tuser, task fields in tdata
//   rsp_*     out   tvalid/tready       verdict in tuser, cpu/charge/count in tdata
//   csr_*     in    psel/penable/APB    active_cpus at 0x0, cpu_capacity at 0x4
//
// One item at a time: it scans the served entries, then drains, reads and updates;
// the next is accepted once its result is in the output register. The table has one
// read port: every request scans it entry by entry, then reads one entry, which place
// and release write back. Reset is synchronous; tables need no clearing pass, valid
// bits make unwritten entries read as cpu_capacity and a zero count. A result waits in
// the output register while the next item is accepted and processed up to its last step.
`timescale 1ns / 1ps

module percpu_utilization_admission (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // tdata: util_demand[16:0], util_known[17], has_period[18], skip_admission[19],
   //        prefers_other[20], held_here[21], held_cpu[26:22], held_util[43:27]
   input  logic [pua_pkg::REQ_DW-1:0]    req_tdata,
   // tuser: req_type[1:0]
   input  logic [pua_pkg::KIND_W-1:0]    req_tuser,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // tdata: chosen_cpu[4:0], charged_util[21:5], cpu_task_count[37:22]
   output logic [pua_pkg::RSP_DW-1:0]    rsp_tdata,
   // tuser: verdict[1:0]
   output logic [pua_pkg::KIND_W-1:0]    rsp_tuser,
   input  logic                          csr_psel,
   input  logic                          csr_penable,
   input  logic                          csr_pwrite,
   input  logic [pua_pkg::CSR_AW-1:0]    csr_paddr,
   input  logic [pua_pkg::CSR_DW-1:0]    csr_pwdata,
   output logic [pua_pkg::CSR_DW-1:0]    csr_prdata,
   output logic                          csr_pready
);
   import pua_pkg::*;

   cmd_type           cmd;
   status_type        status;
   logic [ACT_W-1:0]  active_cpus;
   logic [UTIL_W-1:0] cpu_capacity;
   logic              cap_load;

   pua_csr u_csr (
      .clock        (clock),
      .reset        (reset),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_prdata   (csr_prdata),
      .csr_pready   (csr_pready),
      .active_cpus  (active_cpus),
      .cpu_capacity (cpu_capacity),
      .cap_load     (cap_load)
   );

   pua_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pua_datapath u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser),
      .active_cpus  (active_cpus),
      .cpu_capacity (cpu_capacity),
      .cap_load     (cap_load)
   );

endmodule

/* hw/rtl/pua_checker.sv */
// Port-level checks for the admission block, bound to the top level.
`timescale 1ns / 1ps

module pua_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_tvalid,
   input logic                          req_tready,
   input logic                          rsp_tvalid,
   input logic                          rsp_tready,
   input logic [pua_pkg::RSP_DW-1:0]    rsp_tdata,
   input logic [pua_pkg::KIND_W-1:0]    rsp_tuser
);
   import pua_pkg::*;

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // One item at a time: acceptance closes the input
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("input open right after an accepted item");

   // Only place results carry a charge; test verdicts never do
   a_no_charge: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != V_DONE |-> rsp_tdata[21:5] == '0)
      else $error("charge on a test verdict");

endmodule

bind percpu_utilization_admission pua_checker u_pua_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

/* tb/tb_percpu_utilization_admission.sv */
// Self-checking testbench for the per-processor utilization admission block.
`timescale 1ns / 1ps

module tb_percpu_utilization_admission;
   import pua_pkg::*;

   localparam int LATENCY    = NUM_CPUS + 5;
   localparam int SETTLE     = 2 * LATENCY;
   localparam int CYCLE_CAP  = 1000000;
   localparam int HOLD_AT    = 600;
   localparam int HOLD_LEN   = 400;
   localparam int NUM_PHASES = 7;
   localparam logic [CSR_AW-1:0] ADDR_ACTIVE   = {REG_ACTIVE_CPUS, 2'b00};
   localparam logic [CSR_AW-1:0] ADDR_CAPACITY = {REG_CPU_CAPACITY, 2'b00};

   // One request item as it enters the block
   typedef struct {
      logic [KIND_W-1:0] kind;
      logic [UTIL_W-1:0] util_demand;
      logic              util_known;
      logic              has_period;
      logic              skip_admission;
      logic              prefers_other;
      logic              held_here;
      logic [HCPU_W-1:0] held_cpu;
      logic [UTIL_W-1:0] held_util;
   } request_type;

   // One answer item as it leaves the block
   typedef struct {
      logic [KIND_W-1:0]   verdict;
      logic [HCPU_W-1:0]   chosen_cpu;
      logic [UTIL_W-1:0]   charged_util;
      logic [TCOUNT_W-1:0] cpu_task_count;
   } answer_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_DW-1:0]   req_tdata = '0;
   logic [KIND_W-1:0]   req_tuser = '0;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_DW-1:0]   rsp_tdata;
   logic [KIND_W-1:0]   rsp_tuser;
   logic                csr_psel = 1'b0;
   logic                csr_penable = 1'b0;
   logic                csr_pwrite = 1'b0;
   logic [CSR_AW-1:0]   csr_paddr = '0;
   logic [CSR_DW-1:0]   csr_pwdata = '0;
   logic [CSR_DW-1:0]   csr_prdata;
   logic                csr_pready;

   // Shadow of the block's tables and registers
   logic [FREE_W-1:0]   spare_util [NUM_CPUS];
   logic [TCOUNT_W-1:0] tasks_on [NUM_CPUS];
   logic [ACT_W-1:0]    mdl_active;
   logic [UTIL_W-1:0]   mdl_capacity;

   request_type req_backlog [$];
   answer_type  answers_due [$];
   request_type cur_req;
   int      errors = 0;
   int      cycles = 0;
   int      burst_left = 0;
   int      gap_left = 0;
   int      results_seen = 0;
   int      hold_left = 0;
   bit      hold_done = 0;
   int      stall_mode = 0;
   int      mode_left = 0;

   percpu_utilization_admission dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #6 clock = ~clock;

   // Served processor count: zero acts as one, large values clamp
   function automatic int unsigned served_of(logic [ACT_W-1:0] act);
      if (act == 0)
         return 1;
      if (act > NUM_CPUS)
         return NUM_CPUS;
      return 32'(act);
   endfunction

   function automatic logic [FREE_W-1:0] add_capped(logic [FREE_W-1:0] a,
                                                    logic [UTIL_W-1:0] b);
      logic [FREE_W:0] s;
      s = {1'b0, a} + (FREE_W + 1)'(b);
      return s[FREE_W] ? {FREE_W{1'b1}} : s[FREE_W-1:0];
   endfunction

   // Admission verdict against the current free table
   function automatic logic [KIND_W-1:0] admission(request_type r,
                                                   logic [FREE_W-1:0] demand,
                                                   int unsigned n);
      logic ok;
      if (!r.has_period)
         return V_REJECT;
      ok = r.skip_admission;
      for (int unsigned i = 0; i < n; i++)
         if (demand <= spare_util[i])
            ok = 1'b1;
      if (!ok)
         return V_REJECT;
      return r.prefers_other ? V_PARTIAL : V_ACCEPT;
   endfunction

   // Work out the answer to one request and update the shadow tables
   function automatic answer_type serve_request(request_type r);
      answer_type        a;
      int unsigned       n;
      int unsigned       best;
      logic [FREE_W-1:0] demand;
      logic [FREE_W-1:0] saved;
      n = served_of(mdl_active);
      demand = r.util_known ? FREE_W'(r.util_demand) : '0;
      a.verdict = V_DONE;
      a.chosen_cpu = r.held_cpu;
      a.charged_util = '0;
      case (r.kind)
         REQ_TEST: begin
            a.verdict = admission(r, demand, n);
         end
         REQ_CHANGE: begin
            // held share is given back for the test only
            saved = spare_util[r.held_cpu];
            if (r.held_here && r.held_util != 0)
               spare_util[r.held_cpu] = add_capped(saved, r.held_util);
            a.verdict = admission(r, demand, n);
            spare_util[r.held_cpu] = saved;
         end
         REQ_PLACE: begin
            // worst fit, lowest index on a tie
            best = 0;
            for (int unsigned i = 1; i < n; i++)
               if (spare_util[i] > spare_util[best])
                  best = i;
            spare_util[best] = (spare_util[best] >= demand) ? spare_util[best] - demand : '0;
            if (tasks_on[best] != {TCOUNT_W{1'b1}})
               tasks_on[best]++;
            a.chosen_cpu = HCPU_W'(best);
            a.charged_util = UTIL_W'(demand);
         end
         default: begin
            // release refunds even a task that was never placed
            spare_util[r.held_cpu] = add_capped(spare_util[r.held_cpu], r.held_util);
            if (tasks_on[r.held_cpu] != 0)
               tasks_on[r.held_cpu]--;
         end
      endcase
      a.cpu_task_count = tasks_on[a.chosen_cpu];
      return a;
   endfunction

   function automatic request_type mk(logic [KIND_W-1:0] kind, logic [UTIL_W-1:0] tu,
                                      logic known, logic period, logic skip, logic prefer,
                                      logic here, logic [HCPU_W-1:0] hcpu,
                                      logic [UTIL_W-1:0] hutil);
      request_type r;
      r.kind = kind;
      r.util_demand = tu;
      r.util_known = known;
      r.has_period = period;
      r.skip_admission = skip;
      r.prefers_other = prefer;
      r.held_here = here;
      r.held_cpu = hcpu;
      r.held_util = hutil;
      return r;
   endfunction

   // Utilization values: mostly in range, some edges, some over-range
   function automatic logic [UTIL_W-1:0] rand_util();
      int unsigned pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0: return '0;
         1: return UTIL_W'(65536);
         2: return UTIL_W'($urandom_range(0, 17'h1FFFF));
         3, 4, 5: return UTIL_W'($urandom_range(0, 8192));
         default: return UTIL_W'($urandom_range(0, 65536));
      endcase
   endfunction

   function automatic request_type rand_req(int unsigned n);
      request_type r;
      int unsigned pick;
      pick = $urandom_range(0, 99);
      r.kind = (pick < 30) ? REQ_TEST : (pick < 50) ? REQ_CHANGE :
               (pick < 75) ? REQ_PLACE : REQ_RELEASE;
      r.util_demand = rand_util();
      r.util_known = ($urandom_range(0, 9) != 0);
      r.has_period = ($urandom_range(0, 9) != 0);
      r.skip_admission = ($urandom_range(0, 7) == 0);
      r.prefers_other = ($urandom_range(0, 5) == 0);
      r.held_here = ($urandom_range(0, 4) != 0);
      r.held_cpu = ($urandom_range(0, 5) == 0) ? HCPU_W'($urandom_range(0, 31))
                                                : HCPU_W'($urandom_range(0, n - 1));
      r.held_util = rand_util();
      return r;
   endfunction

   // APB access: setup then access, completes when pready is seen
   task automatic csr_access(logic wr, logic [CSR_AW-1:0] addr, logic [CSR_DW-1:0] wdata,
                             output logic [CSR_DW-1:0] rdata);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= addr;
      csr_pwdata <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      rdata = csr_prdata;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Write both registers, read them back, reload the shadow table
   task automatic set_config(logic [ACT_W-1:0] act, logic [UTIL_W-1:0] cap);
      logic [CSR_DW-1:0] rd;
      csr_access(1'b1, ADDR_ACTIVE, CSR_DW'(act), rd);
      csr_access(1'b1, ADDR_CAPACITY, CSR_DW'(cap), rd);
      mdl_active = act;
      mdl_capacity = cap;
      for (int i = 0; i < NUM_CPUS; i++)
         spare_util[i] = FREE_W'(cap);
      csr_access(1'b0, ADDR_ACTIVE, '0, rd);
      if (rd[ACT_W-1:0] !== act) begin
         $error("active_cpus readback: expected %0d, actual %0d", act, rd[ACT_W-1:0]);
         errors++;
      end
      csr_access(1'b0, ADDR_CAPACITY, '0, rd);
      if (rd[UTIL_W-1:0] !== cap) begin
         $error("cpu_capacity readback: expected %0d, actual %0d", cap, rd[UTIL_W-1:0]);
         errors++;
      end
   endtask

   // Block is idle once nothing is queued, offered or owed
   task automatic wait_drained();
      while (req_backlog.size() != 0 || req_tvalid || answers_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic check_field(string name, logic [RSP_DW-1:0] exp, logic [RSP_DW-1:0] act);
      if (act !== exp) begin
         $error("%s: expected %0d, actual %0d", name, exp, act);
         errors++;
      end
   endtask

   // Request driver: bursts of items with random gaps
   always @(posedge clock) begin
      logic offer;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready)
            answers_due.push_back(serve_request(cur_req));
         offer = req_tvalid && !req_tready;
         if (!offer) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (req_backlog.size() != 0) begin
               cur_req = req_backlog.pop_front();
               req_tdata <= REQ_DW'({cur_req.held_util, cur_req.held_cpu, cur_req.held_here,
                                     cur_req.prefers_other, cur_req.skip_admission,
                                     cur_req.has_period, cur_req.util_known,
                                     cur_req.util_demand});
               req_tuser <= cur_req.kind;
               offer = 1'b1;
               if (burst_left > 1) begin
                  burst_left--;
               end else begin
                  burst_left = $urandom_range(1, 24);
                  if ($urandom_range(0, 2) == 0)
                     gap_left = 0;
                  else if ($urandom_range(0, 4) == 0)
                     gap_left = $urandom_range(20, 60);
                  else
                     gap_left = $urandom_range(1, 10);
               end
            end
         end
         req_tvalid <= offer;
      end
   end

   // One long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
      end else if (!hold_done && !reset && results_seen >= HOLD_AT) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_LEN;
      end
   end

   // Answer monitor and receiver stalls
   always @(posedge clock) begin
      answer_type exp;
      logic       nxt;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            results_seen++;
            if (answers_due.size() == 0) begin
               $error("answer with none outstanding: tuser %0d tdata %0h", rsp_tuser, rsp_tdata);
               errors++;
            end else begin
               exp = answers_due.pop_front();
               check_field("verdict", RSP_DW'(exp.verdict), RSP_DW'(rsp_tuser));
               check_field("chosen_cpu", RSP_DW'(exp.chosen_cpu), RSP_DW'(rsp_tdata[4:0]));
               check_field("charged_util", RSP_DW'(exp.charged_util),
                           RSP_DW'(rsp_tdata[21:5]));
               check_field("cpu_task_count", RSP_DW'(exp.cpu_task_count),
                           RSP_DW'(rsp_tdata[37:22]));
            end
         end
         if (hold_left > 0) begin
            nxt = 1'b0;
         end else begin
            if (mode_left == 0) begin
               stall_mode = $urandom_range(0, 3);
               mode_left = $urandom_range(10, 80);
            end else begin
               mode_left--;
            end
            case (stall_mode)
               0: nxt = 1'b1;
               1: nxt = ($urandom_range(0, 1) == 1);
               2: nxt = ($urandom_range(0, 6) != 0);
               default: nxt = ($urandom_range(0, 4) == 0);
            endcase
         end
         rsp_tready <= nxt;
      end
   end

   // Run limit
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $error("no progress after %0d cycles", cycles);
         $display("CHECK FAILED");
         $finish;
      end
   end

   // Stimulus sequence
   initial begin
      int phase_act [NUM_PHASES];
      int phase_cap [NUM_PHASES];
      int phase_len [NUM_PHASES];
      mdl_active = ACT_W'(32);
      mdl_capacity = UTIL_W'(65536);
      for (int i = 0; i < NUM_CPUS; i++) begin
         spare_util[i] = FREE_W'(65536);
         tasks_on[i] = '0;
      end
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset configuration: verdict kinds, fit edges, placement order
      req_backlog.push_back(mk(REQ_TEST, 1000, 1, 0, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 1000, 1, 0, 1, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 65536, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 100, 1, 1, 0, 1, 0, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 17'h1FFFF, 0, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 17'h1FFFF, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 17'h1FFFF, 1, 1, 1, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_PLACE, 65536, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_PLACE, 40000, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_PLACE, 17'h1FFFF, 0, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_PLACE, 17'h1FFFF, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_RELEASE, 0, 1, 1, 0, 0, 1, 31, 17'h1FFFF));
      wait_drained();

      // One served processor with little room: give-back, unserved refund, saturation
      set_config(ACT_W'(1), UTIL_W'(1000));
      req_backlog.push_back(mk(REQ_TEST, 2000, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_CHANGE, 2000, 1, 1, 0, 0, 1, 0, 1500));
      req_backlog.push_back(mk(REQ_CHANGE, 2000, 1, 1, 0, 0, 0, 0, 1500));
      req_backlog.push_back(mk(REQ_CHANGE, 2000, 1, 1, 0, 0, 1, 0, 0));
      req_backlog.push_back(mk(REQ_TEST, 2000, 1, 1, 0, 0, 0, 0, 0));
      req_backlog.push_back(mk(REQ_RELEASE, 0, 1, 1, 0, 0, 1, 5, 65536));
      req_backlog.push_back(mk(REQ_PLACE, 500, 1, 1, 0, 0, 0, 0, 0));
      for (int i = 0; i < 4; i++)
         req_backlog.push_back(mk(REQ_RELEASE, 0, 1, 1, 0, 0, 1, 0, 17'h1FFFF));
      req_backlog.push_back(mk(REQ_CHANGE, 17'h1FFFF, 1, 1, 0, 1, 1, 0, 17'h1FFFF));
      wait_drained();

      // Random phases over several settings, extremes included
      phase_act = '{4, 0, 63, 32, 1, 33, $urandom_range(1, 32)};
      phase_cap = '{65536, 0, 17'h1FFFF, 1, 65536, $urandom_range(0, 17'h1FFFF),
                    $urandom_range(0, 65536)};
      phase_len = '{300, 150, 250, 300, 200, 250, 450};
      for (int p = 0; p < NUM_PHASES; p++) begin
         set_config(ACT_W'(phase_act[p]), UTIL_W'(phase_cap[p]));
         for (int i = 0; i < phase_len[p]; i++)
            req_backlog.push_back(rand_req(served_of(ACT_W'(phase_act[p]))));
         wait_drained();
      end

      if (errors == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule

/* sim.f */
hw/rtl/pua_pkg.sv
hw/rtl/pua_csr.sv
hw/rtl/pua_ctrl.sv
hw/rtl/pua_datapath.sv
hw/rtl/percpu_utilization_admission.sv
hw/rtl/pua_checker.sv
tb/tb_percpu_utilization_admission.sv
